/* src/rg_chromaticity_histogram_macros.svh */
// ----------------------------------------------------------------------------
// rg chromaticity histogram assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef RG_CHROMATICITY_HISTOGRAM_MACROS_SVH
`define RG_CHROMATICITY_HISTOGRAM_MACROS_SVH

// same-cycle implication, disabled during reset
`define RGCH_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define RGCH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* src/rgch_pkg.sv */
// ----------------------------------------------------------------------------
// rgch_pkg
// shared types and constants of the rg chromaticity histogram
// ----------------------------------------------------------------------------
package rgch_pkg;

    localparam int BINS_DEF = 256;
    localparam int COMP_W   = 8;
    localparam int BIN_W    = 8;
    localparam int COUNT_W  = 32;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic div_step;
        logic mem_rd;
        logic out_fire;
        logic sweep_step;
        logic out_clear;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_last;
        logic sweep_last;
        logic out_stall;
    } t_dp_status;

endpackage

/* src/rgch_div.sv */
// ----------------------------------------------------------------------------
// rgch_div
// restoring divider lane, one quotient bit per step, msb first
// ----------------------------------------------------------------------------
module rgch_div #(
    parameter int QW    = 8,
    parameter int NUM_W = QW + 10
) (
    input  logic             i_clk,
    input  logic             i_load,
    input  logic             i_step,
    input  logic [NUM_W-1:0] i_num,
    input  logic [10:0]      i_den,
    output logic [QW-1:0]    o_quo
);
    logic [NUM_W-1:0] r_rem, n_rem;
    logic [NUM_W-1:0] r_den, n_den;
    logic [QW-1:0]    r_quo, n_quo;
    logic             fits;

    always_comb begin
        fits  = (r_rem >= r_den);
        n_rem = r_rem;
        n_den = r_den;
        n_quo = r_quo;
        if (i_load) begin
            n_rem = i_num;
            n_den = NUM_W'(i_den) << (QW - 1);
            n_quo = '0;
        end else if (i_step) begin
            n_rem = fits ? (r_rem - r_den) : r_rem;
            n_den = r_den >> 1;
            n_quo = QW'({r_quo, fits});
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_quo = r_quo;

endmodule

/* src/rgch_datapath.sv */
// ----------------------------------------------------------------------------
// rgch_datapath
// bin dividers, histogram memory, totals and output register
// ----------------------------------------------------------------------------
module rgch_datapath #(
    parameter int BINS = rgch_pkg::BINS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rgch_pkg::t_dp_cmd     i_cmd,
    input  logic                  i_is_add,
    output rgch_pkg::t_dp_status  o_status,
    input  logic [39:0]           i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [111:0]          o_out_data
);
    import rgch_pkg::*;

    localparam int QW     = $clog2(BINS);
    localparam int NUM_W  = QW + 10;
    localparam int ADDR_W = 2 * QW;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int STEP_W = $clog2(QW + 1);

    logic [COMP_W-1:0] in_red, in_green, in_blue, in_qr, in_qg;
    logic [9:0]        sum, sum_nz;
    logic [10:0]       den;
    logic [NUM_W-1:0]  num_r, num_g;
    logic [QW-1:0]     quo_r, quo_g;

    logic [STEP_W-1:0] r_step;
    logic [ADDR_W-1:0] r_sweep;
    logic              r_is_add;
    logic [BIN_W-1:0]  r_qr, r_qg;
    logic              r_oor;
    logic [COUNT_W-1:0] r_rd_data;
    logic [COUNT_W-1:0] r_largest, n_largest;
    logic [COUNT_W-1:0] r_total, n_total;
    logic [COUNT_W-1:0] inc_cnt, rd_cnt;
    logic [ADDR_W-1:0] acc_addr, wr_addr;
    logic [COUNT_W-1:0] wr_data;
    logic              wr_en;

    logic              r_out_valid;
    logic [BIN_W-1:0]  r_out_r, r_out_g;
    logic [COUNT_W-1:0] r_out_cnt, r_out_largest, r_out_total;

    logic [COUNT_W-1:0] mem [DEPTH];

    assign in_red   = i_in_data[7:0];
    assign in_green = i_in_data[15:8];
    assign in_blue  = i_in_data[23:16];
    assign in_qr    = i_in_data[31:24];
    assign in_qg    = i_in_data[39:32];

    // rounded bin: floor((2*c*(bins-1) + s) / (2*s)), zero sum taken as one
    always_comb begin
        sum    = 10'(in_red) + 10'(in_green) + 10'(in_blue);
        sum_nz = (sum == '0) ? 10'd1 : sum;
        den    = {sum_nz, 1'b0};
        num_r  = ((NUM_W'(in_red) * NUM_W'(BINS - 1)) << 1) + NUM_W'(sum_nz);
        num_g  = ((NUM_W'(in_green) * NUM_W'(BINS - 1)) << 1) + NUM_W'(sum_nz);
    end

    rgch_div #(.QW(QW), .NUM_W(NUM_W)) u_div_r (
        .i_clk  (i_clk),
        .i_load (i_cmd.load_in),
        .i_step (i_cmd.div_step),
        .i_num  (num_r),
        .i_den  (den),
        .o_quo  (quo_r)
    );

    rgch_div #(.QW(QW), .NUM_W(NUM_W)) u_div_g (
        .i_clk  (i_clk),
        .i_load (i_cmd.load_in),
        .i_step (i_cmd.div_step),
        .i_num  (num_g),
        .i_den  (den),
        .o_quo  (quo_g)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_sweep <= '0;
        end else begin
            if (i_cmd.load_in) begin
                r_step <= '0;
            end else if (i_cmd.div_step) begin
                r_step <= r_step + 1'b1;
            end
            if (i_cmd.sweep_step) begin
                r_sweep <= r_sweep + 1'b1;
            end
        end
    end

    // queried bins at or above bins are never counted and read as zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_is_add <= i_is_add;
            r_qr     <= in_qr;
            r_qg     <= in_qg;
            r_oor    <= ({1'b0, in_qr} >= 9'(BINS)) || ({1'b0, in_qg} >= 9'(BINS));
        end
    end

    assign acc_addr = r_is_add ? {quo_r, quo_g} : {r_qr[QW-1:0], r_qg[QW-1:0]};
    assign inc_cnt  = (r_rd_data == COUNT_MAX) ? r_rd_data : r_rd_data + 1'b1;
    assign rd_cnt   = r_oor ? '0 : r_rd_data;

    always_comb begin
        wr_en   = i_cmd.sweep_step || (i_cmd.out_fire && r_is_add);
        wr_addr = i_cmd.sweep_step ? r_sweep : acc_addr;
        wr_data = i_cmd.sweep_step ? '0 : inc_cnt;
        n_largest = (inc_cnt > r_largest) ? inc_cnt : r_largest;
        n_total   = (r_total == COUNT_MAX) ? r_total : r_total + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.mem_rd) begin
            r_rd_data <= mem[acc_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_largest   <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.out_clear) begin
                r_largest <= '0;
                r_total   <= '0;
            end else if (i_cmd.out_fire && r_is_add) begin
                r_largest <= n_largest;
                r_total   <= n_total;
            end
            if (i_cmd.out_fire || i_cmd.out_clear) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_clear) begin
            r_out_r       <= '0;
            r_out_g       <= '0;
            r_out_cnt     <= '0;
            r_out_largest <= '0;
            r_out_total   <= '0;
        end else if (i_cmd.out_fire) begin
            if (r_is_add) begin
                r_out_r       <= BIN_W'(quo_r);
                r_out_g       <= BIN_W'(quo_g);
                r_out_cnt     <= inc_cnt;
                r_out_largest <= n_largest;
                r_out_total   <= n_total;
            end else begin
                r_out_r       <= r_qr;
                r_out_g       <= r_qg;
                r_out_cnt     <= rd_cnt;
                r_out_largest <= r_largest;
                r_out_total   <= r_total;
            end
        end
    end

    assign o_status.div_last   = (r_step == STEP_W'(QW - 1));
    assign o_status.sweep_last = (r_sweep == ADDR_W'(DEPTH - 1));
    assign o_status.out_stall  = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {r_out_total, r_out_largest, r_out_cnt, r_out_g, r_out_r};

endmodule

/* src/rgch_ctrl.sv */
// ----------------------------------------------------------------------------
// rgch_ctrl
// request sequencer: divide, memory access, clearing sweep, result hand-off
// ----------------------------------------------------------------------------
module rgch_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  rgch_pkg::t_op         i_op,
    output logic                  o_is_add,
    output rgch_pkg::t_dp_cmd     o_cmd,
    input  rgch_pkg::t_dp_status  i_status
);
    import rgch_pkg::*;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_DIV,
        ST_RD,
        ST_OUT,
        ST_CLR_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_reply, n_reply;
    logic   accept;

    assign accept     = (r_state == ST_IDLE) && i_in_valid;
    assign o_in_ready = (r_state == ST_IDLE);
    assign o_is_add   = (i_op == OP_ADD);

    always_comb begin
        n_state = r_state;
        n_reply = r_reply;
        o_cmd   = '0;
        unique case (r_state)
            ST_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = r_reply ? ST_CLR_OUT : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.load_in = 1'b1;
                    unique case (i_op)
                        OP_ADD: n_state = ST_DIV;
                        OP_CLEAR: begin
                            n_state = ST_SWEEP;
                            n_reply = 1'b1;
                        end
                        default: n_state = ST_RD;
                    endcase
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = ST_OUT;
            end
            ST_OUT: begin
                if (!i_status.out_stall) begin
                    o_cmd.out_fire = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_CLR_OUT: begin
                if (!i_status.out_stall) begin
                    o_cmd.out_clear = 1'b1;
                    n_reply         = 1'b0;
                    n_state         = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SWEEP;
            r_reply <= 1'b0;
        end else begin
            r_state <= n_state;
            r_reply <= n_reply;
        end
    end

endmodule

/* src/rg_chromaticity_histogram.sv */
// ----------------------------------------------------------------------------
// rg_chromaticity_histogram
// two-dimensional rg chromaticity histogram with bin read and clear
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel: tuser carries the operation (add
// pixel, read bin, clear), tdata the pixel and the queried bin. Each request
// yields one result on m_axis: bins, bin count, largest count, pixel total.
// One request is in work at a time. An add runs clog2(BINS) divider steps,
// one memory read and one read-modify-write; a read does the memory read
// only. The next request is taken once the sequencer has handed its result
// to the output register. A clear sweeps the bin memory one entry a cycle
// over all of its entries, BINS rounded up to a power of two, squared (65536
// at the default), and its result follows. After reset the same sweep runs
// with tready low and no result. The result register lets a new request be
// accepted while the previous result waits; if m_axis stalls, the next
// result holds in the sequencer until the register is free. Counts saturate
// at all ones.
// ----------------------------------------------------------------------------
module rg_chromaticity_histogram #(
    parameter int BINS = rgch_pkg::BINS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [39:0]  i_s_axis_tdata,   // red, green, blue, query_r_bin, query_g_bin
    input  logic [1:0]   i_s_axis_tuser,   // operation
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [111:0] o_m_axis_tdata    // r_bin, g_bin, bin_count, largest_count,
                                           // pixel_total
);
    import rgch_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       is_add;

    rgch_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_op       (t_op'(i_s_axis_tuser)),
        .o_is_add   (is_add),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    rgch_datapath #(.BINS(BINS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_is_add    (is_add),
        .o_status    (status),
        .i_in_data   (i_s_axis_tdata),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule

/* src/rgch_checker.sv */
// ----------------------------------------------------------------------------
// rgch_checker
// port-level checks of the rg chromaticity histogram
// ----------------------------------------------------------------------------
`include "rg_chromaticity_histogram_macros.svh"

module rgch_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic [39:0]  i_s_axis_tdata,
    input logic [1:0]   i_s_axis_tuser,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [111:0] o_m_axis_tdata
);
    logic in_acc;

    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;

    `RGCH_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid, "result dropped while stalled")
    `RGCH_ASSERT_NEXT(a_one_in_flight, in_acc, !o_s_axis_tready, "second request taken while one is in work")
    `RGCH_ASSERT_SAME(a_bin_le_largest, o_m_axis_tvalid, o_m_axis_tdata[47:16] <= o_m_axis_tdata[79:48], "bin count above largest count")
    `RGCH_ASSERT_SAME(a_largest_le_total, o_m_axis_tvalid, o_m_axis_tdata[79:48] <= o_m_axis_tdata[111:80], "largest count above pixel total")

endmodule

bind rg_chromaticity_histogram rgch_checker u_rgch_checker (.*);

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the rg chromaticity histogram
// ----------------------------------------------------------------------------
// A queue of requests is filled up front. The first requests are hand-picked:
// black and saturated pixels, the rounding midpoint, repeated bins, reads at
// the corners of the bin plane, the spare operation code and a clear. Random
// requests follow. Most are pixel adds, many of them from a small palette so
// bins grow. Reads mostly target bins that were recently touched. Two clears
// fall at random points. A clocked driver offers the requests in bursts with
// random gaps. Each accepted request runs through a local histogram model,
// which queues the expected result. A clocked monitor with its own stall
// pattern and one long hold-off compares every result field by field.
// ----------------------------------------------------------------------------
module tb;
    import rgch_pkg::*;

    localparam int unsigned RUN_LIMIT    = 2_000_000;
    localparam int unsigned END_WAIT     = 64;
    localparam int unsigned RANDOM_ITEMS = 1700;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam logic [1:0]  OP_SPARE     = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] query_r;
        logic [7:0] query_g;
    } t_hist_req;

    // packed from the top down, so r_bin lands in the lowest bits
    typedef struct packed {
        logic [31:0] pixel_total;
        logic [31:0] largest_count;
        logic [31:0] bin_count;
        logic [7:0]  g_bin;
        logic [7:0]  r_bin;
    } t_hist_result;

    logic         i_clk    = 1'b0;
    logic         i_rst_n  = 1'b0;
    logic         s_tvalid = 1'b0;
    wire          s_tready;
    logic [39:0]  s_tdata  = '0;      // red, green, blue, query_r_bin, query_g_bin
    logic [1:0]   s_tuser  = OP_ADD;  // operation
    wire          m_tvalid;
    logic         m_tready = 1'b0;
    wire  [111:0] m_tdata;            // r_bin, g_bin, bin_count, largest_count,
                                      // pixel_total

    t_hist_req    pending_reqs[$];
    t_hist_result expected_results[$];
    t_hist_req    offered_req;

    logic [31:0] bin_counts[logic [15:0]];
    logic [31:0] most_seen = '0;
    logic [31:0] pixel_sum = '0;

    logic [23:0] color_palette[0:5] = '{24'h204080, 24'h0000ff, 24'h7f7f7f,
                                        24'h10e030, 24'h010203, 24'hff8000};

    int unsigned accept_cnt = 0;
    int unsigned fail_cnt   = 0;
    int unsigned cycle_cnt  = 0;
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;
    int unsigned stall_left = 0;
    int unsigned stall_mode = 0;
    logic        hold_off   = 1'b0;

    rg_chromaticity_histogram u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // rounded half up: (2*c*(BINS-1) + s) / (2*s)
    function automatic logic [7:0] chroma_bin(logic [7:0] comp, int unsigned total);
        int unsigned num;
        num = 2 * 32'(comp) * (BINS_DEF - 1) + total;
        return 8'(num / (2 * total));
    endfunction

    function automatic logic [15:0] pixel_bin(logic [7:0] red, logic [7:0] green,
                                              logic [7:0] blue);
        int unsigned total;
        total = 32'(red) + 32'(green) + 32'(blue);
        if (total == 0) begin
            total = 1;
        end
        return {chroma_bin(red, total), chroma_bin(green, total)};
    endfunction

    function automatic t_hist_result predict_histogram(t_hist_req req);
        t_hist_result res;
        logic [15:0]  idx;
        logic [31:0]  cnt;
        res = '0;
        case (req.op)
            OP_ADD: begin
                idx = pixel_bin(req.red, req.green, req.blue);
                cnt = bin_counts.exists(idx) ? bin_counts[idx] : '0;
                if (cnt != COUNT_MAX) begin
                    cnt++;
                end
                bin_counts[idx] = cnt;
                {res.r_bin, res.g_bin} = idx;
                res.bin_count = cnt;
                if (cnt > most_seen) begin
                    most_seen = cnt;
                end
                if (pixel_sum != COUNT_MAX) begin
                    pixel_sum++;
                end
            end
            OP_CLEAR: begin
                bin_counts.delete();
                most_seen = '0;
                pixel_sum = '0;
            end
            default: begin
                idx = {req.query_r, req.query_g};
                res.r_bin = req.query_r;
                res.g_bin = req.query_g;
                res.bin_count = bin_counts.exists(idx) ? bin_counts[idx] : '0;
            end
        endcase
        res.largest_count = most_seen;
        res.pixel_total = pixel_sum;
        return res;
    endfunction

    task automatic push_req(logic [1:0] op, logic [7:0] red, logic [7:0] green,
                            logic [7:0] blue, logic [7:0] query_r, logic [7:0] query_g);
        pending_reqs.push_back('{op, red, green, blue, query_r, query_g});
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(predict_histogram(offered_req));
                accept_cnt++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    offered_req = pending_reqs.pop_front();
                    s_tdata <= {offered_req.query_g, offered_req.query_r, offered_req.blue,
                                offered_req.green, offered_req.red};
                    s_tuser <= offered_req.op;
                    s_tvalid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin : watch_results
        t_hist_result want;
        t_hist_result got;
        logic         ready_next;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no request pending: %h", m_tdata);
                    fail_cnt++;
                end else begin
                    got = m_tdata;
                    want = expected_results.pop_front();
                    check_field("r_bin", 32'(want.r_bin), 32'(got.r_bin));
                    check_field("g_bin", 32'(want.g_bin), 32'(got.g_bin));
                    check_field("bin_count", want.bin_count, got.bin_count);
                    check_field("largest_count", want.largest_count, got.largest_count);
                    check_field("pixel_total", want.pixel_total, got.pixel_total);
                end
            end
            if (stall_left != 0) begin
                stall_left--;
            end else begin
                stall_mode = $urandom_range(0, 2);
                stall_left = $urandom_range(32, 256);
            end
            case (stall_mode)
                0: ready_next = 1'b1;
                1: ready_next = 1'($urandom_range(0, 1));
                default: ready_next = ($urandom_range(0, 3) == 0);
            endcase
            m_tready <= ready_next && !hold_off;
        end
    end

    // long receiver hold-off so the block backs up into its input
    initial begin
        wait (accept_cnt >= 200);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= RUN_LIMIT) begin
            $display("** rg_chromaticity_histogram: FAILED **");
            $finish;
        end
    end

    initial begin : run_control
        logic [15:0] recent_bins[$];
        logic [23:0] color;
        logic [15:0] query;
        int unsigned clear_a;
        int unsigned clear_b;
        int unsigned roll;

        // black pixel twice, white, primaries, midpoint rounding
        push_req(OP_ADD, 8'd0, 8'd0, 8'd0, 8'($urandom), 8'($urandom));
        push_req(OP_ADD, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255);
        push_req(OP_ADD, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0);
        push_req(OP_ADD, 8'd255, 8'd0, 8'd0, 8'($urandom), 8'($urandom));
        push_req(OP_ADD, 8'd0, 8'd255, 8'd0, 8'($urandom), 8'($urandom));
        push_req(OP_ADD, 8'd0, 8'd0, 8'd255, 8'($urandom), 8'($urandom));
        push_req(OP_ADD, 8'd1, 8'd0, 8'd0, 8'($urandom), 8'($urandom));
        push_req(OP_ADD, 8'd1, 8'd1, 8'd0, 8'($urandom), 8'($urandom));
        push_req(OP_ADD, 8'd85, 8'd85, 8'd85, 8'($urandom), 8'($urandom));
        push_req(OP_ADD, 8'd1, 8'd2, 8'd0, 8'($urandom), 8'($urandom));
        // reads at the corners and at the grey bin
        push_req(OP_READ, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0);
        push_req(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'd255, 8'd0);
        push_req(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'd0, 8'd255);
        push_req(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'd255, 8'd255);
        push_req(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'd85, 8'd85);
        push_req(OP_SPARE, 8'($urandom), 8'($urandom), 8'($urandom), 8'd85, 8'd85);
        push_req(OP_SPARE, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255);
        push_req(OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom), 8'($urandom));
        push_req(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'd85, 8'd85);
        push_req(OP_ADD, 8'd0, 8'd0, 8'd0, 8'($urandom), 8'($urandom));
        push_req(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'd0, 8'd0);

        // each clear sweeps the whole store, so keep them few
        clear_a = $urandom_range(400, 800);
        clear_b = $urandom_range(1000, 1500);
        for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
            roll = $urandom_range(0, 99);
            if (i == clear_a || i == clear_b) begin
                push_req(OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom));
            end else if (roll < 62) begin
                roll = $urandom_range(0, 99);
                if (roll < 40) begin
                    color = color_palette[$urandom_range(0, 5)];
                end else if (roll < 55) begin
                    color = {6'd0, 2'($urandom), 6'd0, 2'($urandom), 6'd0, 2'($urandom)};
                end else begin
                    color = 24'($urandom);
                end
                recent_bins.push_back(pixel_bin(color[23:16], color[15:8], color[7:0]));
                if (recent_bins.size() > 64) begin
                    void'(recent_bins.pop_front());
                end
                push_req(OP_ADD, color[23:16], color[15:8], color[7:0],
                         8'($urandom), 8'($urandom));
            end else begin
                if (recent_bins.size() != 0 && $urandom_range(0, 99) < 70) begin
                    query = recent_bins[$urandom_range(0, recent_bins.size() - 1)];
                end else begin
                    query = 16'($urandom);
                end
                push_req((roll < 94) ? OP_READ : OP_SPARE, 8'($urandom), 8'($urandom),
                         8'($urandom), query[15:8], query[7:0]);
            end
        end

        do begin
            @(posedge i_clk);
        end while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (END_WAIT) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("** rg_chromaticity_histogram: PASSED **");
        end else begin
            $display("** rg_chromaticity_histogram: FAILED **");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/rgch_pkg.sv
src/rgch_div.sv
src/rgch_datapath.sv
src/rgch_ctrl.sv
src/rg_chromaticity_histogram.sv
src/rgch_checker.sv
sim/tb.sv
